// ----- rtl/tup_pkg.sv -----
// ----------------------------------------------------------------------------
// tup_pkg: shared types and constants of the text to unsigned parser
// Character codes, radix constants, parser phases and result status codes.
// ----------------------------------------------------------------------------
package tup_pkg;

   localparam int BASE_BITS  = 6;
   localparam int CHAR_BITS  = 8;
   localparam int DIGIT_BITS = 6;

   typedef logic [BASE_BITS-1:0]  base_type;
   typedef logic [CHAR_BITS-1:0]  char_type;
   typedef logic [DIGIT_BITS-1:0] digit_type;

   localparam base_type BASE_AUTO    = 6'd0;
   localparam base_type BASE_UNARY   = 6'd1;
   localparam base_type BASE_OCTAL   = 6'd8;
   localparam base_type BASE_DECIMAL = 6'd10;
   localparam base_type BASE_HEX     = 6'd16;
   localparam base_type BASE_MAX     = 6'd36;
   localparam base_type BASE_RESET   = 6'd10;

   // digit code for a character that is no letter or decimal digit
   localparam digit_type DIGIT_NONE = 6'd36;

   localparam char_type CHAR_SPACE   = 8'h20;
   localparam char_type CHAR_TAB     = 8'h09;
   localparam char_type CHAR_NEWLINE = 8'h0A;
   localparam char_type CHAR_PLUS    = 8'h2B;
   localparam char_type CHAR_MINUS   = 8'h2D;
   localparam char_type CHAR_ZERO    = 8'h30;
   localparam char_type CHAR_NINE    = 8'h39;
   localparam char_type CHAR_LOWER_A = 8'h61;
   localparam char_type CHAR_LOWER_X = 8'h78;
   localparam char_type CHAR_LOWER_Z = 8'h7A;
   localparam char_type CHAR_UPPER_A = 8'h41;
   localparam char_type CHAR_UPPER_X = 8'h58;
   localparam char_type CHAR_UPPER_Z = 8'h5A;

   typedef enum logic [2:0] {
      PHASE_IDLE,
      PHASE_LEAD,
      PHASE_SIGNED,
      PHASE_ZERO,
      PHASE_X,
      PHASE_DIGITS
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_OVERFLOW,
      STATUS_NO_DIGITS,
      STATUS_BAD_BASE
   } status_type;

   // digit value of a character, DIGIT_NONE when it is not alphanumeric
   function automatic digit_type digit_of(input char_type c);
      char_type d;
      begin
         d = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, DIGIT_NONE};
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
         end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d = c - CHAR_LOWER_A + 8'd10;
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d = c - CHAR_UPPER_A + 8'd10;
         end
         return d[DIGIT_BITS-1:0];
      end
   endfunction

endpackage

// ----- rtl/tup_if.sv -----
// ----------------------------------------------------------------------------
// tup_if: request and response channels of the text to unsigned parser
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tup_req_if;
   logic                valid;
   logic                ready;
   tup_pkg::char_type   character;
   logic                first_char;

   modport source (output valid, output character, output first_char, input ready);
   modport sink   (input valid, input character, input first_char, output ready);
endinterface

interface tup_rsp_if #(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_BITS-1:0]  value;
   logic [COUNT_BITS-1:0]  consumed;
   tup_pkg::status_type    status;

   modport source (output valid, output value, output consumed, output status, input ready);
   modport sink   (input valid, input value, input consumed, input status, output ready);
endinterface

// ----- rtl/text_to_unsigned_parser_core.sv -----
// ----------------------------------------------------------------------------
// text_to_unsigned_parser_core: streaming string to unsigned converter
// Parses text one character per request and returns one result per text.
// ----------------------------------------------------------------------------
// Each request carries one character; first_char marks the start of a text and
// drops any text still open. The parser skips space, tab and newline, takes one
// optional sign, honors a 0x prefix in base 0 or 16 only when a hex digit
// follows, and accumulates digits up to base 36. The first non-digit (NUL
// included) closes the text with one response: value (negated modulo
// 2^VALUE_BITS after a minus, all ones on overflow), consumed (saturating at
// 2^COUNT_BITS-1, zero when no digit was seen) and status. A base of 1 or above
// 36 answers the first character at once with status invalid base. The base
// register is sampled on the first character of each text. Throughput is one
// character per clock while no closing character waits on a stalled response:
// the request register feeds one multiply-accumulate (value times a 6-bit base
// plus digit) and the state update in the same cycle, which loads the result
// into the output register. A waiting response holds in the output register
// while further characters keep stepping through the request register; only
// a character that closes another text waits for the response slot to drain.
// ----------------------------------------------------------------------------
module text_to_unsigned_parser_core #(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   tup_req_if.sink              req_ch,
   tup_rsp_if.source            rsp_ch,
   input  logic                 csr_write_en,
   input  tup_pkg::base_type    csr_write_data
);

   // base register
   tup_pkg::base_type       number_base_ff;

   // request register
   logic                    in_valid_ff, in_valid_in;
   tup_pkg::char_type       in_char_ff;
   logic                    in_first_ff;

   // response register
   logic                    out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0]   out_value_ff;
   logic [COUNT_BITS-1:0]   out_consumed_ff;
   tup_pkg::status_type     out_status_ff;

   logic                    req_take;
   logic                    advance;
   logic                    hit;
   logic [VALUE_BITS-1:0]   hit_value;
   logic [COUNT_BITS-1:0]   hit_consumed;
   tup_pkg::status_type     hit_status;

   // step the held character unless it closes a text while the response slot is stalled
   assign advance      = in_valid_ff && (!hit || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = (advance && hit) ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= tup_pkg::BASE_RESET;
      end else if (csr_write_en) begin
         number_base_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // capture the payload only on a new request
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff  <= req_ch.character;
         in_first_ff <= req_ch.first_char;
      end
   end

   tup_parse #(
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .character    (in_char_ff),
      .first_char   (in_first_ff),
      .cfg_base     (number_base_ff),
      .hit          (hit),
      .hit_value    (hit_value),
      .hit_consumed (hit_consumed),
      .hit_status   (hit_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // load a finished result; hold while the sink stalls
   always_ff @(posedge clock) begin
      if (advance && hit) begin
         out_value_ff    <= hit_value;
         out_consumed_ff <= hit_consumed;
         out_status_ff   <= hit_status;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.value    = out_value_ff;
   assign rsp_ch.consumed = out_consumed_ff;
   assign rsp_ch.status   = out_status_ff;

endmodule

// ----- rtl/tup_mac.sv -----
// ----------------------------------------------------------------------------
// tup_mac: digit multiply-accumulate with overflow detect
// Forms acc * base + digit at full width and flags a carry out of the value.
// ----------------------------------------------------------------------------
module tup_mac #(
   parameter int VALUE_BITS = 32
) (
   input  logic [VALUE_BITS-1:0]   acc,
   input  tup_pkg::base_type       base,
   input  tup_pkg::digit_type      digit,
   output logic                    is_digit,
   output logic [VALUE_BITS-1:0]   sum,
   output logic                    overflow
);

   localparam int PROD_BITS = VALUE_BITS + tup_pkg::BASE_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;

   logic [PROD_BITS-1:0] product;
   logic [SUM_BITS-1:0]  full_sum;

   assign is_digit = (base >= 6'd2) && (digit < base);
   assign product  = acc * base;
   assign full_sum = {1'b0, product} + {{(SUM_BITS-tup_pkg::DIGIT_BITS){1'b0}}, digit};
   assign sum      = full_sum[VALUE_BITS-1:0];
   assign overflow = |full_sum[SUM_BITS-1:VALUE_BITS];

endmodule

// ----- rtl/tup_parse.sv -----
// ----------------------------------------------------------------------------
// tup_parse: per-character parser state and next-state logic
// Holds the open text's state and steps it by one character per strobe.
// ----------------------------------------------------------------------------
module tup_parse #(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  tup_pkg::char_type       character,
   input  logic                    first_char,
   input  tup_pkg::base_type       cfg_base,
   output logic                    hit,
   output logic [VALUE_BITS-1:0]   hit_value,
   output logic [COUNT_BITS-1:0]   hit_consumed,
   output tup_pkg::status_type     hit_status
);

   tup_pkg::phase_type      phase_ff, phase_in, cur_phase;
   logic [VALUE_BITS-1:0]   acc_ff, acc_in, cur_acc;
   tup_pkg::base_type       base_ff, base_in, cur_base, eff_base;
   logic                    minus_ff, minus_in, cur_minus;
   logic                    ovf_ff, ovf_in, cur_ovf;
   logic                    seen_ff, seen_in, cur_seen;
   logic [COUNT_BITS-1:0]   count_ff, count_in, cur_count, count_inc;
   logic [COUNT_BITS-1:0]   mark_ff, mark_in, cur_mark;

   logic                    bad_base;
   logic                    is_zero_char;
   tup_pkg::digit_type      digit;
   logic                    mac_is_digit;
   logic [VALUE_BITS-1:0]   mac_sum;
   logic                    mac_overflow;

   assign bad_base = (cfg_base == tup_pkg::BASE_UNARY) || (cfg_base > tup_pkg::BASE_MAX);

   // a new text starts from cleared state with the base sampled now
   assign cur_phase = first_char ? (bad_base ? tup_pkg::PHASE_IDLE : tup_pkg::PHASE_LEAD)
                                 : phase_ff;
   assign cur_acc   = first_char ? '0 : acc_ff;
   assign cur_base  = first_char ? cfg_base : base_ff;
   assign cur_minus = first_char ? 1'b0 : minus_ff;
   assign cur_ovf   = first_char ? 1'b0 : ovf_ff;
   assign cur_seen  = first_char ? 1'b0 : seen_ff;
   assign cur_count = first_char ? '0 : count_ff;
   assign cur_mark  = first_char ? '0 : mark_ff;

   assign count_inc    = (cur_count == {COUNT_BITS{1'b1}}) ? cur_count
                                                           : cur_count + 1'b1;
   assign is_zero_char = (character == tup_pkg::CHAR_ZERO);
   assign digit        = tup_pkg::digit_of(character);

   always_comb begin
      if (cur_phase == tup_pkg::PHASE_X) begin
         eff_base = tup_pkg::BASE_HEX;
      end else if (cur_base == tup_pkg::BASE_AUTO) begin
         eff_base = is_zero_char ? tup_pkg::BASE_OCTAL : tup_pkg::BASE_DECIMAL;
      end else begin
         eff_base = cur_base;
      end
   end

   tup_mac #(.VALUE_BITS(VALUE_BITS)) u_mac (
      .acc      (cur_acc),
      .base     (eff_base),
      .digit    (digit),
      .is_digit (mac_is_digit),
      .sum      (mac_sum),
      .overflow (mac_overflow)
   );

   always_comb begin
      logic start;
      logic prefix;
      logic do_take;
      logic do_finish;
      logic use_mark;

      phase_in     = cur_phase;
      acc_in       = cur_acc;
      base_in      = cur_base;
      minus_in     = cur_minus;
      ovf_in       = cur_ovf;
      seen_in      = cur_seen;
      count_in     = cur_count;
      mark_in      = cur_mark;
      hit          = 1'b0;
      hit_value    = '0;
      hit_consumed = '0;
      hit_status   = tup_pkg::STATUS_OK;
      start        = 1'b0;
      do_take      = 1'b0;
      do_finish    = 1'b0;
      use_mark     = 1'b0;
      prefix       = ((cur_base == tup_pkg::BASE_AUTO) || (cur_base == tup_pkg::BASE_HEX))
                     && is_zero_char;

      case (cur_phase)
         tup_pkg::PHASE_LEAD: begin
            if (character == tup_pkg::CHAR_SPACE || character == tup_pkg::CHAR_TAB ||
                character == tup_pkg::CHAR_NEWLINE) begin
               count_in = count_inc;
            end else if (character == tup_pkg::CHAR_PLUS ||
                         character == tup_pkg::CHAR_MINUS) begin
               minus_in = (character == tup_pkg::CHAR_MINUS);
               count_in = count_inc;
               phase_in = tup_pkg::PHASE_SIGNED;
            end else begin
               start = 1'b1;
            end
         end
         tup_pkg::PHASE_SIGNED: begin
            start = 1'b1;
         end
         tup_pkg::PHASE_ZERO: begin
            if (character == tup_pkg::CHAR_LOWER_X || character == tup_pkg::CHAR_UPPER_X) begin
               count_in = count_inc;
               phase_in = tup_pkg::PHASE_X;
            end else begin
               do_take = 1'b1;
            end
         end
         tup_pkg::PHASE_X: begin
            // a hex digit after the prefix goes on; with none, the number is the lone zero
            do_take  = 1'b1;
            use_mark = 1'b1;
         end
         tup_pkg::PHASE_DIGITS: begin
            do_take = 1'b1;
         end
         default: begin
         end
      endcase

      if (start) begin
         base_in = eff_base;
         do_take = 1'b1;
      end

      if (do_take) begin
         if (mac_is_digit) begin
            base_in  = eff_base;
            seen_in  = 1'b1;
            count_in = count_inc;
            if (mac_overflow) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = mac_sum;
            end
            if (start && prefix) begin
               mark_in  = count_inc;
               phase_in = tup_pkg::PHASE_ZERO;
            end else begin
               phase_in = tup_pkg::PHASE_DIGITS;
            end
         end else begin
            do_finish = 1'b1;
         end
      end

      if (do_finish) begin
         hit      = 1'b1;
         phase_in = tup_pkg::PHASE_IDLE;
         if (!cur_seen) begin
            hit_status = tup_pkg::STATUS_NO_DIGITS;
         end else if (cur_ovf) begin
            hit_value    = {VALUE_BITS{1'b1}};
            hit_consumed = use_mark ? cur_mark : cur_count;
            hit_status   = tup_pkg::STATUS_OVERFLOW;
         end else begin
            hit_value    = cur_minus ? (~cur_acc + 1'b1) : cur_acc;
            hit_consumed = use_mark ? cur_mark : cur_count;
            hit_status   = tup_pkg::STATUS_OK;
         end
      end

      if (first_char && bad_base) begin
         hit        = 1'b1;
         hit_status = tup_pkg::STATUS_BAD_BASE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tup_pkg::PHASE_IDLE;
         acc_ff   <= '0;
         base_ff  <= tup_pkg::BASE_AUTO;
         minus_ff <= 1'b0;
         ovf_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         count_ff <= '0;
         mark_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         minus_ff <= minus_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         count_ff <= count_in;
         mark_ff  <= mark_in;
      end
   end

endmodule

// ----- rtl/tup_checker.sv -----
// ----------------------------------------------------------------------------
// tup_checker: port-level checks of the text to unsigned parser
// Watches the response channel for stall behavior and status consistency.
// ----------------------------------------------------------------------------
module tup_checker #(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [VALUE_BITS-1:0]  rsp_value,
   input  logic [COUNT_BITS-1:0]  rsp_consumed,
   input  tup_pkg::status_type    rsp_status
);

   property p_stall_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
                                     $stable(rsp_consumed) && $stable(rsp_status);
   endproperty
   a_stall_hold: assert property (p_stall_hold)
      else $error("response changed while stalled");

   property p_empty_result;
      @(posedge clock) disable iff (reset)
         rsp_valid && (rsp_status == tup_pkg::STATUS_NO_DIGITS ||
                       rsp_status == tup_pkg::STATUS_BAD_BASE)
         |-> rsp_value == '0 && rsp_consumed == '0;
   endproperty
   a_empty_result: assert property (p_empty_result)
      else $error("no-digit or invalid-base response carries data");

   property p_overflow_ones;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_status == tup_pkg::STATUS_OVERFLOW
         |-> rsp_value == {VALUE_BITS{1'b1}};
   endproperty
   a_overflow_ones: assert property (p_overflow_ones)
      else $error("overflow response is not all ones");

   property p_digits_counted;
      @(posedge clock) disable iff (reset)
         rsp_valid && (rsp_status == tup_pkg::STATUS_OK ||
                       rsp_status == tup_pkg::STATUS_OVERFLOW)
         |-> rsp_consumed != '0;
   endproperty
   a_digits_counted: assert property (p_digits_counted)
      else $error("converted number reports no consumed characters");

endmodule

bind text_to_unsigned_parser_core tup_checker #(
   .VALUE_BITS (VALUE_BITS),
   .COUNT_BITS (COUNT_BITS)
) u_tup_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_value    (rsp_ch.value),
   .rsp_consumed (rsp_ch.consumed),
   .rsp_status   (rsp_ch.status)
);
